>>> hdl/plk_pkg.sv
// ----------------------------------------------------------------------------
// plk_pkg
// Shared types and constants of the piecewise linear lookup.
// ----------------------------------------------------------------------------
package plk_pkg;

    localparam int MAX_POINTS = 256;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int COORD_W    = 16;
    localparam int NUM_W      = 2 * COORD_W + 2;
    localparam int STEP_W     = $clog2(NUM_W + 1);

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [2:0] ADDR_POINT_COUNT = 3'd0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MUL,
        S_SUM,
        S_DIV
    } t_state;

    // Point write broadcast to every cell.
    typedef struct packed {
        logic                      en;
        logic [IDX_W-1:0]          idx;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_wr;

    // Query token handed from cell to cell.
    typedef struct packed {
        logic                      valid;
        logic signed [COORD_W-1:0] qx;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic                      done;
        logic                      interp;
        logic signed [COORD_W-1:0] ey;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic signed [COORD_W-1:0] x2;
        logic signed [COORD_W-1:0] y2;
    } t_tok;

endpackage

>>> hdl/plk_cell.sv
// ----------------------------------------------------------------------------
// plk_cell
// Holds one table point and tests the segment from the previous point.
// ----------------------------------------------------------------------------
module plk_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [plk_pkg::IDX_W-1:0]    i_idx,
    input  logic [plk_pkg::CNT_W-1:0]    i_n,
    input  plk_pkg::t_wr                 i_wr,
    input  plk_pkg::t_tok                i_tok,
    output plk_pkg::t_tok                o_tok
);

    logic signed [plk_pkg::COORD_W-1:0] r_x;
    logic signed [plk_pkg::COORD_W-1:0] r_y;
    plk_pkg::t_tok r_tok;
    plk_pkg::t_tok n_tok;
    logic          seg;

    always_ff @(posedge i_clk) begin
        if (i_wr.en && i_wr.idx == i_idx) begin
            r_x <= i_wr.x;
            r_y <= i_wr.y;
        end
    end

    // Segment from point idx-1 to point idx exists when idx is below the count.
    assign seg = i_tok.valid && !i_tok.done && (i_idx != '0)
                 && ({1'b0, i_idx} < i_n);

    always_comb begin
        n_tok    = i_tok;
        n_tok.px = r_x;
        n_tok.py = r_y;
        if (seg) begin
            if (i_tok.qx > i_tok.px && i_tok.qx < r_x) begin
                n_tok.done   = 1'b1;
                n_tok.interp = 1'b1;
                n_tok.x1     = i_tok.px;
                n_tok.y1     = i_tok.py;
                n_tok.x2     = r_x;
                n_tok.y2     = r_y;
            end else if (i_tok.qx == i_tok.px) begin
                n_tok.done = 1'b1;
                n_tok.ey   = i_tok.py;
            end else if (i_tok.qx == r_x) begin
                n_tok.done = 1'b1;
                n_tok.ey   = r_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.qx     <= n_tok.qx;
        r_tok.px     <= n_tok.px;
        r_tok.py     <= n_tok.py;
        r_tok.done   <= n_tok.done;
        r_tok.interp <= n_tok.interp;
        r_tok.ey     <= n_tok.ey;
        r_tok.x1     <= n_tok.x1;
        r_tok.y1     <= n_tok.y1;
        r_tok.x2     <= n_tok.x2;
        r_tok.y2     <= n_tok.y2;
    end

    assign o_tok = r_tok;

endmodule

>>> hdl/plk_div.sv
// ----------------------------------------------------------------------------
// plk_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module plk_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [plk_pkg::NUM_W-1:0]     i_num,
    input  logic [plk_pkg::COORD_W-1:0]   i_den,
    output logic                          o_busy,
    output logic                          o_done,
    output logic [plk_pkg::NUM_W-1:0]     o_quo
);

    logic                          r_busy;
    logic                          r_done;
    logic [plk_pkg::STEP_W-1:0]    r_cnt;
    logic [plk_pkg::COORD_W-1:0]   r_rem;
    logic [plk_pkg::NUM_W-1:0]     r_quo;
    logic [plk_pkg::COORD_W-1:0]   r_den;
    logic [plk_pkg::COORD_W:0]     trial;
    logic                          take;

    assign trial = {r_rem, r_quo[plk_pkg::NUM_W-1]};
    assign take  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == plk_pkg::STEP_W'(plk_pkg::NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= take ? plk_pkg::COORD_W'(trial - {1'b0, r_den})
                          : trial[plk_pkg::COORD_W-1:0];
            r_quo <= {r_quo[plk_pkg::NUM_W-2:0], take};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

>>> hdl/piecewise_linear_lookup.sv
// ----------------------------------------------------------------------------
// piecewise_linear_lookup
// Polyline table with segment search and exact integer interpolation.
// ----------------------------------------------------------------------------
// A transaction is accepted when start is high and busy is low. A write
// (command 0) stores point (x, y) at point_index and gives no result; busy
// stays low, so writes can follow each other in every cycle. A query (command
// 1) sends a token down a row of 256 cells, one cell per cycle; cell i holds
// point i and checks the segment ending at it, and the first matching segment
// is kept. The scan runs through all cells whatever the count. An interior hit
// then passes a multiply state, a sum state that loads the divider and 34
// restoring divider steps. The result strobe follows the end of the scan (end
// point hit or miss) or of the divider (interior hit); busy is high until then
// and falls in the strobe cycle, where the next transaction can be accepted.
// The result shows on o_y_value and o_found for one cycle with o_strobe high;
// the receiver cannot stall it. The user writes point_count via APB address 0
// only while idle; the block does not enforce this. Reset clears point_count
// and the control state; the table stays undefined until written.
// ----------------------------------------------------------------------------
module piecewise_linear_lookup (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_command,
    input  logic [plk_pkg::IDX_W-1:0]           i_point_index,
    input  logic signed [plk_pkg::COORD_W-1:0]  i_coord_x,
    input  logic signed [plk_pkg::COORD_W-1:0]  i_coord_y,
    output logic                                o_strobe,
    output logic signed [plk_pkg::COORD_W-1:0]  o_y_value,
    output logic                                o_found,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    plk_pkg::t_state r_state;
    plk_pkg::t_state n_state;

    logic [plk_pkg::CNT_W-1:0] r_count;
    logic [plk_pkg::CNT_W-1:0] n_eff;
    plk_pkg::t_wr              wr;
    plk_pkg::t_tok             tok [0:plk_pkg::MAX_POINTS];
    plk_pkg::t_tok             tail;
    plk_pkg::t_tok             r_hit;

    logic                      accept;
    logic                      cfg_wr;
    logic                      div_start;
    logic                      div_busy;
    logic                      div_done;
    logic [plk_pkg::NUM_W-1:0] div_quo;

    logic signed [plk_pkg::NUM_W-1:0] r_p1;
    logic signed [plk_pkg::NUM_W-1:0] r_p2;
    logic signed [plk_pkg::NUM_W-1:0] num;
    logic [plk_pkg::NUM_W-1:0]        num_mag;
    logic [plk_pkg::COORD_W-1:0]      r_den;
    logic                             r_neg;
    logic [plk_pkg::NUM_W-1:0]        quo_s;

    logic                             r_strobe;
    logic signed [plk_pkg::COORD_W-1:0] r_y;
    logic                             r_found;

    assign accept = start && !busy;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr == plk_pkg::ADDR_POINT_COUNT)
                    ? {{(32 - plk_pkg::CNT_W){1'b0}}, r_count} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (cfg_wr && paddr == plk_pkg::ADDR_POINT_COUNT) begin
            r_count <= pwdata[plk_pkg::CNT_W-1:0];
        end
    end

    assign n_eff = (r_count > plk_pkg::CNT_W'(plk_pkg::MAX_POINTS))
                   ? plk_pkg::CNT_W'(plk_pkg::MAX_POINTS) : r_count;

    assign wr.en  = accept && i_command == plk_pkg::CMD_WRITE;
    assign wr.idx = i_point_index;
    assign wr.x   = i_coord_x;
    assign wr.y   = i_coord_y;

    always_comb begin
        tok[0]        = '0;
        tok[0].valid  = accept && i_command == plk_pkg::CMD_QUERY;
        tok[0].qx     = i_coord_x;
    end

    for (genvar g = 0; g < plk_pkg::MAX_POINTS; g++) begin : g_cell
        plk_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (plk_pkg::IDX_W'(g)),
            .i_n     (n_eff),
            .i_wr    (wr),
            .i_tok   (tok[g]),
            .o_tok   (tok[g+1])
        );
    end

    assign tail = tok[plk_pkg::MAX_POINTS];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            plk_pkg::S_IDLE: begin
                if (accept && i_command == plk_pkg::CMD_QUERY) n_state = plk_pkg::S_SCAN;
            end
            plk_pkg::S_SCAN: begin
                if (tail.valid) begin
                    n_state = (tail.done && tail.interp) ? plk_pkg::S_MUL : plk_pkg::S_IDLE;
                end
            end
            plk_pkg::S_MUL:  n_state = plk_pkg::S_SUM;
            plk_pkg::S_SUM:  n_state = plk_pkg::S_DIV;
            plk_pkg::S_DIV:  if (div_done) n_state = plk_pkg::S_IDLE;
            default:         n_state = plk_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        busy      = (r_state != plk_pkg::S_IDLE);
        div_start = (r_state == plk_pkg::S_SUM);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= plk_pkg::S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == plk_pkg::S_SCAN && tail.valid
                         && !(tail.done && tail.interp))
                        || (r_state == plk_pkg::S_DIV && div_done);
        end
    end

    // Numerator y1*(x2-x1) + (y2-y1)*(x-x1); the products are registered first.
    always_ff @(posedge i_clk) begin
        if (r_state == plk_pkg::S_SCAN && tail.valid) begin
            r_hit <= tail;
        end
        if (r_state == plk_pkg::S_MUL) begin
            r_p1  <= plk_pkg::NUM_W'($signed({r_hit.y1[plk_pkg::COORD_W-1], r_hit.y1})
                     * ($signed({r_hit.x2[plk_pkg::COORD_W-1], r_hit.x2})
                      - $signed({r_hit.x1[plk_pkg::COORD_W-1], r_hit.x1})));
            r_p2  <= plk_pkg::NUM_W'(($signed({r_hit.y2[plk_pkg::COORD_W-1], r_hit.y2})
                      - $signed({r_hit.y1[plk_pkg::COORD_W-1], r_hit.y1}))
                     * ($signed({r_hit.qx[plk_pkg::COORD_W-1], r_hit.qx})
                      - $signed({r_hit.x1[plk_pkg::COORD_W-1], r_hit.x1})));
            r_den <= plk_pkg::COORD_W'(r_hit.x2 - r_hit.x1);
        end
        if (r_state == plk_pkg::S_SUM) begin
            r_neg <= num[plk_pkg::NUM_W-1];
        end
    end

    assign num     = r_p1 + r_p2;
    assign num_mag = num[plk_pkg::NUM_W-1] ? plk_pkg::NUM_W'(-num) : plk_pkg::NUM_W'(num);

    plk_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num_mag),
        .i_den   (r_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign quo_s = r_neg ? (~div_quo + 1'b1) : div_quo;

    always_ff @(posedge i_clk) begin
        if (r_state == plk_pkg::S_SCAN && tail.valid) begin
            r_found <= tail.done;
            r_y     <= tail.done ? tail.ey : '0;
        end else if (r_state == plk_pkg::S_DIV && div_done) begin
            r_found <= 1'b1;
            r_y     <= quo_s[plk_pkg::COORD_W-1:0];
        end
    end

    assign o_strobe  = r_strobe;
    assign o_y_value = r_y;
    assign o_found   = r_found;

    a_div_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_busy |-> busy) else $error("divider runs while the block is idle");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe) else $error("result strobe held two cycles");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_command == plk_pkg::CMD_QUERY) |=> busy)
        else $error("query accepted without going busy");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy) else $error("result shown while still busy");

endmodule
